// File: rtl/core/nonuniform_table_bilinear_interp_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the table interpolator RTL
// Each macro expects clk_i and rst_ni in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef NONUNIFORM_TABLE_BILINEAR_INTERP_TOP_DEFINES_SVH
`define NONUNIFORM_TABLE_BILINEAR_INTERP_TOP_DEFINES_SVH

// same-cycle implication
`define NTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/nti_pkg.sv
// ----------------------------------------------------------------------------
// nti_pkg
// Types, codes and sizes shared by the table interpolator modules.
// ----------------------------------------------------------------------------
package nti_pkg;

  localparam int NTI_MAX_ROWS   = 8;
  localparam int NTI_MAX_POINTS = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int DIV_W          = 41;
  localparam int DEN_W          = 24;

  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_LOAD  = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NODATA = 2'd2;
  localparam logic [1:0] ST_ZKEY   = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_QRY,
    OP_ZKEY
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] alpha;
    logic [23:0]        reynolds;
    logic signed [15:0] coef;
  } item_t;

endpackage

// File: rtl/core/nti_front.sv
// ----------------------------------------------------------------------------
// nti_front
// Takes commands, classifies them and hands them to the work queue.
// ----------------------------------------------------------------------------
module nti_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          func_i,
  input  logic signed [15:0]  alpha_i,
  input  logic [23:0]         reynolds_i,
  input  logic signed [15:0]  coef_in_i,
  input  logic                q_full_i,
  output logic                push_o,
  output nti_pkg::item_t      item_o
);
  import nti_pkg::*;

  logic  fv_q, fv_d;
  item_t fr_q, fr_d;
  op_e   op;
  logic  accept;

  always_comb begin
    case (func_i)
      FN_CLEAR: op = OP_CLR;
      FN_LOAD:  op = (reynolds_i == '0) ? OP_ZKEY : OP_LOAD;
      FN_QUERY: op = OP_QRY;
      default:  op = OP_NOP;
    endcase
  end

  assign push_o = fv_q & ~q_full_i;
  assign busy_o = fv_q & q_full_i;
  assign accept = start_i & ~busy_o;
  assign item_o = fr_q;

  always_comb begin
    fv_d = fv_q;
    fr_d = fr_q;
    if (accept) begin
      fv_d = 1'b1;
      fr_d = '{op: op, alpha: alpha_i, reynolds: reynolds_i, coef: coef_in_i};
    end else if (push_o) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_q <= fr_d;
  end

endmodule

// File: rtl/core/nti_queue.sv
// ----------------------------------------------------------------------------
// nti_queue
// Short FIFO between the command front and the table engine.
// ----------------------------------------------------------------------------
`include "nonuniform_table_bilinear_interp_top_defines.svh"

module nti_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nti_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output nti_pkg::item_t item_o
);
  import nti_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            ent_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PtrW'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `NTI_ASSERT_IMP(a_no_overflow, push_i, !full_o, "push into full queue")
  `NTI_ASSERT_IMP(a_no_underflow, pop_i, valid_o, "pop from empty queue")
  `NTI_ASSERT_NXT(a_push_shows, push_i && !pop_i, valid_o, "pushed item not visible")

endmodule

// File: rtl/core/nti_div.sv
// ----------------------------------------------------------------------------
// nti_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nti_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [nti_pkg::DIV_W-1:0] dvd_i,
  input  logic [nti_pkg::DEN_W-1:0] dvs_i,
  output logic                      done_o,
  output logic [nti_pkg::DIV_W-1:0] quo_o
);
  import nti_pkg::*;

  localparam int CntW = $clog2(DIV_W + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DIV_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W:0]   rem_sh, rem_nx;
  logic             take;

  always_comb begin
    rem_sh = {rem_q, acc_q[DIV_W-1]};
    take   = (rem_sh >= {1'b0, dvs_i});
    rem_nx = take ? rem_sh - {1'b0, dvs_i} : rem_sh;
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dvd_i;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[DIV_W-2:0], take};
      rem_q <= rem_nx[DEN_W-1:0];
    end
  end

endmodule

// File: rtl/core/nti_back.sv
// ----------------------------------------------------------------------------
// nti_back
// Table engine: row directory, point memory, lookup and insert sequencer.
// ----------------------------------------------------------------------------
`include "nonuniform_table_bilinear_interp_top_defines.svh"

module nti_back #(
  parameter int MAX_ROWS   = nti_pkg::NTI_MAX_ROWS,
  parameter int MAX_POINTS = nti_pkg::NTI_MAX_POINTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_vld_i,
  input  nti_pkg::item_t     item_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic signed [15:0] coef_out_o,
  output logic [1:0]         status_o
);
  import nti_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int PCW   = $clog2(MAX_POINTS + 1);
  localparam int Depth = MAX_ROWS * MAX_POINTS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RSCAN, S_PRD, S_PCMP, S_SHRD, S_SHWR, S_PWR,
    S_QSCAN, S_RVRD, S_RVCMP, S_RVEND, S_DIVGO, S_DIVW,
    S_LOG, S_NLQ, S_NROW, S_NMUL1, S_NMUL2, S_NPRD, S_NPCMP, S_NPADD
  } state_e;

  typedef enum logic [1:0] {PH_ONE, PH_LO, PH_HI} phase_e;

  function automatic logic [AW-1:0] maddr(logic [RW-1:0] s, logic [PCW-1:0] j);
    return AW'(int'(s) * MAX_POINTS + int'(j));
  endfunction

  state_e state_q, lret_q;
  phase_e ph_q;

  // row directory, kept in key order
  logic [23:0]    key_q  [MAX_ROWS];
  logic [PCW-1:0] pts_q  [MAX_ROWS];
  logic [RW-1:0]  slot_q [MAX_ROWS];
  logic [RCW-1:0] rows_q;

  logic [31:0] mem [Depth];
  logic [31:0] rd_q, wdata;
  logic [AW-1:0] raddr, waddr;
  logic ren, we;

  logic signed [15:0] a_q, c_q, pa_q, pc_q, val_q, vlo_q, ybase_q, bcoef_q;
  logic [23:0]        re_q, klo_q, khi_q, den_q, lx_q;
  logic [RCW-1:0]     i_q;
  logic [PCW-1:0]     j_q, k_q, n_q, nlo_q, nhi_q;
  logic [RW-1:0]      s_q, ri_q, slo_q, shi_q;
  logic               dv_re_q, bestv_q;
  logic signed [41:0] prod_q;
  logic [4:0]         ln_q;
  logic [12:0]        lq_q, lres_q;
  logic signed [21:0] drp_q;
  logic [27:0]        drr_q;
  logic [33:0]        da2_q;
  logic [34:0]        best_q;
  logic               vld_q;
  logic signed [15:0] cout_q;
  logic [1:0]         st_q;

  logic [RW-1:0]      ri;
  logic [23:0]        cur_key;
  logic [PCW-1:0]     cur_pts;
  logic [RW-1:0]      cur_slot;
  logic               scan_more;
  logic signed [15:0] rd_ang, rd_cf;
  logic signed [16:0] dy_ang, dx_ang, dn_ang, dy_re, da, q_s;
  logic signed [24:0] dx_re;
  logic signed [41:0] prod_ang, prod_re;
  logic               prod_neg, div_go, div_done;
  logic [DIV_W-1:0]   div_dvd, div_quo;
  logic signed [15:0] lerp_res;
  logic signed [13:0] ldiff;
  logic signed [21:0] drp_d;
  logic [21:0]        drp_mag;
  logic [13:0]        dr_abs;
  logic [27:0]        dr_sq;
  logic [16:0]        da_abs;
  logic [33:0]        da_sq;
  logic [34:0]        pt_dist;

  assign ri        = i_q[RW-1:0];
  assign cur_key   = key_q[ri];
  assign cur_pts   = pts_q[ri];
  assign cur_slot  = slot_q[ri];
  assign scan_more = (i_q < rows_q) && (cur_key < re_q);
  assign rd_ang    = rd_q[31:16];
  assign rd_cf     = rd_q[15:0];

  // lerp operands
  assign dy_ang   = 17'(rd_cf) - 17'(pc_q);
  assign dx_ang   = 17'(a_q) - 17'(pa_q);
  assign dn_ang   = 17'(rd_ang) - 17'(pa_q);
  assign prod_ang = 42'(dy_ang) * 42'(dx_ang);
  assign dy_re    = 17'(val_q) - 17'(vlo_q);
  assign dx_re    = $signed({1'b0, re_q}) - $signed({1'b0, klo_q});
  assign prod_re  = 42'(dy_re) * 42'(dx_re);

  // divide magnitude, then restore the sign so the quotient truncates toward zero
  assign prod_neg = prod_q[41];
  assign div_dvd  = prod_neg ? DIV_W'(-prod_q) : DIV_W'(prod_q);
  assign q_s      = prod_neg ? -$signed({1'b0, div_quo[15:0]}) : $signed({1'b0, div_quo[15:0]});
  assign lerp_res = 16'(17'(ybase_q) + q_s);
  assign div_go   = (state_q == S_DIVGO);

  // nearest-point distance terms
  assign ldiff   = $signed({1'b0, lq_q}) - $signed({1'b0, lres_q});
  assign drp_d   = 22'(ldiff) * 22'sd77;
  assign drp_mag = drp_q[21] ? 22'(-drp_q) : 22'(drp_q);
  assign dr_abs  = drp_mag[21:8];
  assign dr_sq   = 28'(dr_abs) * 28'(dr_abs);
  assign da      = 17'(a_q) - 17'(rd_ang);
  assign da_abs  = da[16] ? 17'(-da) : 17'(da);
  assign da_sq   = 34'(da_abs) * 34'(da_abs);
  assign pt_dist = 35'(da2_q) + 35'(drr_q);

  nti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .dvd_i   (div_dvd),
    .dvs_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    ren   = 1'b0;
    we    = 1'b0;
    raddr = maddr(s_q, j_q);
    waddr = maddr(s_q, j_q);
    wdata = {a_q, c_q};
    case (state_q)
      S_PRD, S_RVRD, S_NPRD: ren = (j_q != n_q);
      S_SHRD: begin
        ren   = (k_q != j_q);
        raddr = maddr(s_q, k_q - PCW'(1));
      end
      S_SHWR: begin
        we    = 1'b1;
        waddr = maddr(s_q, k_q);
        wdata = rd_q;
      end
      S_PWR:   we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rd_q <= mem[raddr];
    end
  end

  assign pop_o      = (state_q == S_IDLE) && item_vld_i;
  assign valid_o    = vld_q;
  assign coef_out_o = cout_q;
  assign status_o   = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rows_q  <= '0;
      vld_q   <= 1'b0;
      cout_q  <= '0;
      st_q    <= ST_OK;
    end else begin
      vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (item_vld_i) begin
            a_q     <= item_i.alpha;
            re_q    <= item_i.reynolds;
            c_q     <= item_i.coef;
            i_q     <= '0;
            bestv_q <= 1'b0;
            cout_q  <= '0;
            case (item_i.op)
              OP_CLR: begin
                rows_q <= '0;
                vld_q  <= 1'b1;
                st_q   <= ST_OK;
              end
              OP_LOAD: state_q <= S_RSCAN;
              OP_QRY: begin
                if (rows_q == '0) begin
                  vld_q <= 1'b1;
                  st_q  <= ST_NODATA;
                end else begin
                  state_q <= S_QSCAN;
                end
              end
              OP_ZKEY: begin
                vld_q <= 1'b1;
                st_q  <= ST_ZKEY;
              end
              default: begin
                vld_q <= 1'b1;
                st_q  <= ST_OK;
              end
            endcase
          end
        end

        S_RSCAN: begin
          if (scan_more) begin
            i_q <= i_q + RCW'(1);
          end else if ((i_q < rows_q) && (cur_key == re_q)) begin
            ri_q <= ri;
            s_q  <= cur_slot;
            n_q  <= cur_pts;
            j_q  <= '0;
            if (cur_pts >= PCW'(MAX_POINTS)) begin
              vld_q   <= 1'b1;
              st_q    <= ST_FULL;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_PRD;
            end
          end else if (rows_q == RCW'(MAX_ROWS)) begin
            vld_q   <= 1'b1;
            st_q    <= ST_FULL;
            state_q <= S_IDLE;
          end else begin
            // open a new row at the scan position, new rows take the next free slot
            for (int e = 1; e < MAX_ROWS; e++) begin
              if (RCW'(e) > i_q) begin
                key_q[e]  <= key_q[e-1];
                pts_q[e]  <= pts_q[e-1];
                slot_q[e] <= slot_q[e-1];
              end
            end
            key_q[ri]  <= re_q;
            pts_q[ri]  <= '0;
            slot_q[ri] <= RW'(rows_q);
            rows_q     <= rows_q + RCW'(1);
            ri_q       <= ri;
            s_q        <= RW'(rows_q);
            n_q        <= '0;
            j_q        <= '0;
            state_q    <= S_PRD;
          end
        end

        S_PRD: begin
          if (j_q == n_q) begin
            k_q     <= n_q;
            state_q <= S_SHRD;
          end else begin
            state_q <= S_PCMP;
          end
        end

        S_PCMP: begin
          if ((rd_ang < a_q) || ((rd_ang == a_q) && (rd_cf <= c_q))) begin
            j_q     <= j_q + PCW'(1);
            state_q <= S_PRD;
          end else begin
            k_q     <= n_q;
            state_q <= S_SHRD;
          end
        end

        S_SHRD: state_q <= (k_q == j_q) ? S_PWR : S_SHWR;

        S_SHWR: begin
          k_q     <= k_q - PCW'(1);
          state_q <= S_SHRD;
        end

        S_PWR: begin
          pts_q[ri_q] <= n_q + PCW'(1);
          vld_q       <= 1'b1;
          st_q        <= ST_OK;
          state_q     <= S_IDLE;
        end

        S_QSCAN: begin
          j_q <= '0;
          if (scan_more) begin
            klo_q <= cur_key;
            slo_q <= cur_slot;
            nlo_q <= cur_pts;
            i_q   <= i_q + RCW'(1);
          end else if (i_q == rows_q) begin
            s_q     <= slo_q;
            n_q     <= nlo_q;
            ph_q    <= PH_ONE;
            state_q <= S_RVRD;
          end else if (i_q == '0) begin
            s_q     <= cur_slot;
            n_q     <= cur_pts;
            ph_q    <= PH_ONE;
            state_q <= S_RVRD;
          end else begin
            khi_q <= cur_key;
            shi_q <= cur_slot;
            nhi_q <= cur_pts;
            if ((nlo_q < PCW'(2)) || (cur_pts < PCW'(2))) begin
              lx_q    <= re_q;
              ln_q    <= 5'd23;
              lret_q  <= S_NLQ;
              state_q <= S_LOG;
            end else begin
              s_q     <= slo_q;
              n_q     <= nlo_q;
              ph_q    <= PH_LO;
              state_q <= S_RVRD;
            end
          end
        end

        S_RVRD: begin
          if (n_q == '0) begin
            val_q   <= '0;
            state_q <= S_RVEND;
          end else if (j_q == n_q) begin
            // clamp above the last angle
            val_q   <= pc_q;
            state_q <= S_RVEND;
          end else begin
            state_q <= S_RVCMP;
          end
        end

        S_RVCMP: begin
          if (rd_ang < a_q) begin
            pa_q    <= rd_ang;
            pc_q    <= rd_cf;
            j_q     <= j_q + PCW'(1);
            state_q <= S_RVRD;
          end else if (j_q == '0) begin
            val_q   <= rd_cf;
            state_q <= S_RVEND;
          end else begin
            prod_q  <= prod_ang;
            ybase_q <= pc_q;
            den_q   <= {8'd0, dn_ang[15:0]};
            dv_re_q <= 1'b0;
            state_q <= S_DIVGO;
          end
        end

        S_RVEND: begin
          case (ph_q)
            PH_LO: begin
              vlo_q   <= val_q;
              s_q     <= shi_q;
              n_q     <= nhi_q;
              j_q     <= '0;
              ph_q    <= PH_HI;
              state_q <= S_RVRD;
            end
            PH_HI: begin
              prod_q  <= prod_re;
              ybase_q <= vlo_q;
              den_q   <= khi_q - klo_q;
              dv_re_q <= 1'b1;
              state_q <= S_DIVGO;
            end
            default: begin
              vld_q   <= 1'b1;
              cout_q  <= val_q;
              st_q    <= ST_OK;
              state_q <= S_IDLE;
            end
          endcase
        end

        S_DIVGO: state_q <= S_DIVW;

        S_DIVW: begin
          if (div_done) begin
            if (dv_re_q) begin
              vld_q   <= 1'b1;
              cout_q  <= lerp_res;
              st_q    <= ST_OK;
              state_q <= S_IDLE;
            end else begin
              val_q   <= lerp_res;
              state_q <= S_RVEND;
            end
          end
        end

        // leading-one search, one bit per cycle
        S_LOG: begin
          if (lx_q == '0) begin
            lres_q  <= '0;
            state_q <= lret_q;
          end else if (lx_q[23]) begin
            lres_q  <= {ln_q, lx_q[22:15]};
            state_q <= lret_q;
          end else begin
            lx_q <= {lx_q[22:0], 1'b0};
            ln_q <= ln_q - 5'd1;
          end
        end

        S_NLQ: begin
          lq_q    <= lres_q;
          i_q     <= '0;
          state_q <= S_NROW;
        end

        S_NROW: begin
          if (i_q == rows_q) begin
            vld_q   <= 1'b1;
            cout_q  <= bcoef_q;
            st_q    <= ST_OK;
            state_q <= S_IDLE;
          end else begin
            lx_q    <= cur_key;
            ln_q    <= 5'd23;
            s_q     <= cur_slot;
            n_q     <= cur_pts;
            lret_q  <= S_NMUL1;
            state_q <= S_LOG;
          end
        end

        S_NMUL1: begin
          drp_q   <= drp_d;
          state_q <= S_NMUL2;
        end

        S_NMUL2: begin
          drr_q   <= dr_sq;
          j_q     <= '0;
          state_q <= S_NPRD;
        end

        S_NPRD: begin
          if (j_q == n_q) begin
            i_q     <= i_q + RCW'(1);
            state_q <= S_NROW;
          end else begin
            state_q <= S_NPCMP;
          end
        end

        S_NPCMP: begin
          da2_q   <= da_sq;
          state_q <= S_NPADD;
        end

        S_NPADD: begin
          // first strictly smaller distance wins
          if (!bestv_q || (pt_dist < best_q)) begin
            best_q  <= pt_dist;
            bcoef_q <= rd_cf;
            bestv_q <= 1'b1;
          end
          j_q     <= j_q + PCW'(1);
          state_q <= S_NPRD;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  `NTI_ASSERT_IMP(a_rows_bound, 1'b1, rows_q <= RCW'(MAX_ROWS), "row count past limit")
  `NTI_ASSERT_IMP(a_err_zero, vld_q && (st_q != ST_OK), cout_q == '0, "nonzero coef on error")
  `NTI_ASSERT_IMP(a_div_wait, div_done, state_q == S_DIVW, "divider done outside wait")

endmodule

// File: rtl/core/nonuniform_table_bilinear_interp_top.sv
// ----------------------------------------------------------------------------
// nonuniform_table_bilinear_interp_top
// Coefficient table keyed by Reynolds number with bilinear lookup.
// ----------------------------------------------------------------------------
// Commands enter on start_i/busy_o: a command transfers at a clock edge with
// start_i high and busy_o low. func_i selects clear, load point or query.
// Every command yields one result on coef_out_o/status_o, marked by valid_o
// for exactly one cycle; the receiver must take it then, there is no stall.
// Results come back in command order. A two-entry queue sits between the
// command stage and the table engine, so up to three commands can be taken
// ahead of the engine before busy_o rises.
// Engine work per command, after the front register and the queue:
//   clear, unused code, zero key: answered straight from idle.
//   load: scans the rows passed and the points passed, then moves the
//     points above the new one up and writes it.
//   bracketed query: scans the rows passed and the points passed in both
//     rows, with up to three divisions; edge-row query: scans the rows
//     passed and the points passed, and divides when it interpolates.
//   nearest-point query: a leading-one search per row, a distance per point.
// The divider is serial, one quotient bit a cycle. After reset the table is
// empty and no result is pending.
// ----------------------------------------------------------------------------
module nonuniform_table_bilinear_interp_top #(
  parameter int MAX_ROWS   = nti_pkg::NTI_MAX_ROWS,
  parameter int MAX_POINTS = nti_pkg::NTI_MAX_POINTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] alpha_i,
  input  logic [23:0]        reynolds_i,
  input  logic signed [15:0] coef_in_i,
  output logic               valid_o,
  output logic signed [15:0] coef_out_o,
  output logic [1:0]         status_o
);
  import nti_pkg::*;

  item_t f_item, q_item;
  logic  push, q_full, q_valid, pop;

  nti_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .alpha_i    (alpha_i),
    .reynolds_i (reynolds_i),
    .coef_in_i  (coef_in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (f_item)
  );

  nti_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  nti_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (q_valid),
    .item_i     (q_item),
    .pop_o      (pop),
    .valid_o    (valid_o),
    .coef_out_o (coef_out_o),
    .status_o   (status_o)
  );

endmodule

// File: tb/sv/tb_nonuniform_table_bilinear_interp_top.sv
// ----------------------------------------------------------------------------
// Coefficient table interpolator testbench
// Drives clear, load, query and unused commands into the table interpolator.
// A behavioral copy of the table predicts every result, and the results are
// checked in order. Random sets are mostly well-formed tables (several rows,
// several points) followed by queries; some commands are noise.
// ----------------------------------------------------------------------------
module tb_nonuniform_table_bilinear_interp_top;
  import nti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = NTI_MAX_ROWS;
  localparam int PTS  = NTI_MAX_POINTS;
  localparam logic [1:0] FN_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] alpha;
    logic [23:0]        reynolds;
    logic signed [15:0] coef;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] coef;
    logic [1:0]         status;
  } answer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         func_i = FN_CLEAR;
  logic signed [15:0] alpha_i = '0;
  logic [23:0]        reynolds_i = '0;
  logic signed [15:0] coef_in_i = '0;
  logic               valid_o;
  logic signed [15:0] coef_out_o;
  logic [1:0]         status_o;
  logic               took = 1'b0;

  nonuniform_table_bilinear_interp_top dut (.*);

  // table model
  int unsigned tbl_rows;
  int unsigned tbl_key [ROWS];
  int unsigned tbl_cnt [ROWS];
  int          tbl_ang [ROWS][PTS];
  int          tbl_cf  [ROWS][PTS];

  cmd_t    cmd_q[$];
  answer_t answer_q[$];
  int      errors = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_queries = 0;
  int      idle_pct = 30;
  logic [23:0] key_pool [ROWS];

  initial forever #1 clk_i = ~clk_i;

  function automatic int lerp_q(longint x1, longint x2, longint y1, longint y2, longint x);
    if (x2 == x1) return int'(y1);
    return int'(y1 + ((y2 - y1) * (x - x1)) / (x2 - x1));
  endfunction

  function automatic int row_coef(int r, int a);
    int i;
    int n;
    n = tbl_cnt[r];
    i = 0;
    if (n == 0) return 0;
    while (i < n && tbl_ang[r][i] < a) i++;
    if (i == 0) return tbl_cf[r][0];
    if (i == n) return tbl_cf[r][n-1];
    return lerp_q(tbl_ang[r][i-1], tbl_ang[r][i], tbl_cf[r][i-1], tbl_cf[r][i], a);
  endfunction

  function automatic int log2_q8(int unsigned x);
    int unsigned n;
    int unsigned fr;
    n = 0;
    if (x == 0) return 0;
    while (n < 31 && (x >> (n + 1)) != 0) n++;
    if (n >= 8) fr = (x >> (n - 8)) & 8'hFF;
    else fr = (x << (8 - n)) & 8'hFF;
    return int'(n * 256 + fr);
  endfunction

  function automatic int closest_coef(int a, int unsigned re);
    longint unsigned best;
    longint unsigned d;
    longint dr;
    longint da;
    int c;
    int lq;
    best = '1;
    c = 0;
    lq = log2_q8(re);
    for (int r = 0; r < tbl_rows; r++) begin
      dr = (longint'(lq - log2_q8(tbl_key[r])) * 77) / 256;
      for (int p = 0; p < tbl_cnt[r]; p++) begin
        da = longint'(a) - tbl_ang[r][p];
        d = longint'(da * da) + longint'(dr * dr);
        if (d < best) begin
          best = d;
          c = tbl_cf[r][p];
        end
      end
    end
    return c;
  endfunction

  function automatic logic [1:0] insert_point(int a, int unsigned key, int c);
    int r;
    int i;
    int n;
    r = 0;
    i = 0;
    if (key == 0) return ST_ZKEY;
    while (r < tbl_rows && tbl_key[r] < key) r++;
    if (r == tbl_rows || tbl_key[r] != key) begin
      if (tbl_rows >= ROWS) return ST_FULL;
      for (int k = tbl_rows; k > r; k--) begin
        tbl_key[k] = tbl_key[k-1];
        tbl_cnt[k] = tbl_cnt[k-1];
        tbl_ang[k] = tbl_ang[k-1];
        tbl_cf[k]  = tbl_cf[k-1];
      end
      tbl_key[r] = key;
      tbl_cnt[r] = 0;
      tbl_rows++;
    end
    n = tbl_cnt[r];
    if (n >= PTS) return ST_FULL;
    while (i < n && (tbl_ang[r][i] < a || (tbl_ang[r][i] == a && tbl_cf[r][i] <= c))) i++;
    for (int k = n; k > i; k--) begin
      tbl_ang[r][k] = tbl_ang[r][k-1];
      tbl_cf[r][k]  = tbl_cf[r][k-1];
    end
    tbl_ang[r][i] = a;
    tbl_cf[r][i]  = c;
    tbl_cnt[r]    = n + 1;
    return ST_OK;
  endfunction

  function automatic int lookup_coef(int a, int unsigned re);
    int i;
    i = 0;
    while (i < tbl_rows && tbl_key[i] < re) i++;
    if (i == tbl_rows) return row_coef(tbl_rows - 1, a);
    if (i == 0) return row_coef(0, a);
    if (tbl_cnt[i-1] < 2 || tbl_cnt[i] < 2) return closest_coef(a, re);
    return lerp_q(tbl_key[i-1], tbl_key[i], row_coef(i-1, a), row_coef(i, a), re);
  endfunction

  function automatic answer_t predict_answer(cmd_t c);
    answer_t r;
    r = '0;
    case (c.func)
      FN_CLEAR: tbl_rows = 0;
      FN_LOAD:  r.status = insert_point(c.alpha, c.reynolds, c.coef);
      FN_QUERY: begin
        if (tbl_rows == 0) r.status = ST_NODATA;
        else r.coef = 16'(lookup_coef(c.alpha, c.reynolds));
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_cmd(logic [1:0] f, int a, int unsigned re, int c);
    cmd_t x;
    x.func = f;
    x.alpha = 16'(a);
    x.reynolds = 24'(re);
    x.coef = 16'(c);
    cmd_q.push_back(x);
  endtask

  // a clear, a few rows of random points, then queries over and around them
  task automatic push_table_set();
    int nrows;
    int npts;
    int span;
    nrows = $urandom_range(1, ROWS + 1);
    span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(64, 4000);
    push_cmd(FN_CLEAR, $urandom, $urandom, $urandom);
    for (int r = 0; r < ROWS; r++) key_pool[r] = ($urandom_range(0, 4) == 0) ?
      24'($urandom) : 24'($urandom_range(1, 200000));
    for (int r = 0; r < nrows; r++) begin
      npts = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 5);
      for (int p = 0; p < npts; p++)
        push_cmd(FN_LOAD, $urandom_range(0, 2 * span) - span,
                 key_pool[r % ROWS], $urandom);
    end
    for (int q = 0; q < $urandom_range(3, 8); q++)
      push_cmd(FN_QUERY, $urandom_range(0, 2 * span + 200) - span - 100,
               ($urandom_range(0, 2) == 0) ? key_pool[$urandom_range(0, ROWS - 1)]
                                           : $urandom_range(0, 220000), 0);
    if ($urandom_range(0, 5) == 0) push_cmd(FN_SPARE, $urandom, $urandom, $urandom);
  endtask

  // record whether the offered command transferred at this rising edge
  always @(posedge clk_i) begin
    took <= rst_ni && start_i && !busy_o;
  end

  // driver: offer at falling edge, hold until a transfer is seen
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took) begin
        n_sent <= n_sent + 1;
        answer_q.push_back(predict_answer({func_i, alpha_i, reynolds_i, coef_in_i}));
      end
      if (took || !start_i) begin
        if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cmd_t x;
          x = cmd_q.pop_front();
          start_i    <= 1'b1;
          func_i     <= x.func;
          alpha_i    <= x.alpha;
          reynolds_i <= x.reynolds;
          coef_in_i  <= x.coef;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: prediction runs at the negedge after the transfer edge, which is
  // always before the earliest result edge given the front-end latency
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result coef=%0d status=%0d", $time, coef_out_o, status_o);
        errors++;
      end else begin
        answer_t e;
        e = answer_q.pop_front();
        n_checked++;
        if (e.coef !== coef_out_o)
          $display("%0t: coef mismatch expected %0d actual %0d", $time, e.coef, coef_out_o);
        if (e.status !== status_o)
          $display("%0t: status mismatch expected %0d actual %0d", $time, e.status,
                   status_o);
        if (e.coef !== coef_out_o || e.status !== status_o) errors++;
      end
    end
  end

  // count queries from the stimulus, not the DUT
  function automatic void tally();
    foreach (cmd_q[i]) if (cmd_q[i].func == FN_QUERY) n_queries++;
  endfunction

  task automatic drain();
    while (cmd_q.size() > 0 || start_i || answer_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int total;
    tbl_rows = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty query, zero key, extremes, duplicates, full row and table
    push_cmd(FN_QUERY, 0, 100, 0);
    push_cmd(FN_LOAD, 100, 0, 5);
    push_cmd(FN_SPARE, -1, 24'hFFFFFF, -1);
    push_cmd(FN_LOAD, -32768, 24'hFFFFFF, -32768);
    push_cmd(FN_LOAD, 32767, 24'hFFFFFF, 32767);
    push_cmd(FN_LOAD, 0, 1, 100);
    push_cmd(FN_LOAD, 0, 1, 100);
    push_cmd(FN_LOAD, 0, 1, -100);
    push_cmd(FN_QUERY, 0, 1, 0);
    push_cmd(FN_QUERY, -32768, 0, 0);
    push_cmd(FN_QUERY, 32767, 24'hFFFFFF, 0);
    push_cmd(FN_QUERY, 1000, 24'h800000, 0);
    push_cmd(FN_LOAD, 50, 5000, 7);
    push_cmd(FN_QUERY, 40, 3000, 0);
    push_cmd(FN_CLEAR, 0, 0, 0);
    push_cmd(FN_QUERY, 0, 1, 0);
    for (int p = 0; p <= PTS; p++) push_cmd(FN_LOAD, p * 256, 77, p * 100);
    for (int r = 1; r <= ROWS; r++) push_cmd(FN_LOAD, r, r * 1000, r);
    push_cmd(FN_QUERY, 1000, 77, 0);
    push_cmd(FN_QUERY, 3, 2500, 0);
    tally();
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 30 : (phase == 1) ? 68 : 0;
      total = 0;
      while (total < 450) begin
        int before_sz;
        before_sz = cmd_q.size();
        push_table_set();
        total += cmd_q.size() - before_sz;
      end
      tally();
      drain();
    end

    $display("Covered %0d commands (%0d queries), %0d results checked, %0d errors.",
             n_sent, n_queries, n_checked, errors);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule
